@@ rtl/prq_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// prq_pkg
// Types and codes shared by the run queue top level and its storage cells.
// -----------------------------------------------------------------------------
package prq_pkg;

   localparam logic [1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [1:0] CMD_REMOVE  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  task_id;
      logic [15:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_task_id;
      logic [15:0] out_priority;
      logic [1:0]  status;
      logic        preempt;
   } rsp_type;

   // One stored slot as seen by its neighbors.
   typedef struct packed {
      logic        valid;
      logic [7:0]  task_id;
      logic [15:0] prio;
   } entry_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic        fire;
      logic [1:0]  cmd;
      logic [7:0]  task_id;
      logic [15:0] prio;
      logic        full;
   } bcast_type;

endpackage
`default_nettype wire

@@ rtl/priority_run_queue.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// priority_run_queue
// Bounded run queue of task identifiers sorted by priority, lower first.
// -----------------------------------------------------------------------------
// The queue is a row of CAPACITY cells, one per slot, kept in service order;
// every command updates all cells in parallel, so the block accepts one item per
// cycle while its output is free and returns its result in the next cycle from an
// output register. A new item is taken in the same cycle as the waiting result
// is taken; a result held by the receiver stalls the input until it leaves. The
// longest path is the remove search, a first-match chain through all cells.
// Enqueue is stable (behind equal priorities) and raises preempt when accepted;
// dequeue on an empty queue, enqueue on a full one and remove of an absent
// task are reported in the status field. No clearing pass after reset.
module priority_run_queue #(
   parameter int CAPACITY = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  prq_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output prq_pkg::rsp_type  rsp_payload
);
   import prq_pkg::*;

   entry_type             cell_entry [CAPACITY];
   logic [CAPACITY-1:0]   cell_shift;
   logic [CAPACITY:0]     hit_chain;
   bcast_type             bcast;
   logic                  req_fire;
   logic                  is_empty;
   logic                  is_full;
   logic                  found;
   rsp_type               rsp_in;
   rsp_type               rsp_payload_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_empty  = !cell_entry[0].valid;
   assign is_full   = cell_entry[CAPACITY-1].valid;
   assign found     = hit_chain[CAPACITY];
   assign hit_chain[0] = 1'b0;

   assign bcast.fire    = req_fire;
   assign bcast.cmd     = req_payload.cmd;
   assign bcast.task_id = req_payload.task_id;
   assign bcast.prio    = req_payload.priority_req;
   assign bcast.full    = is_full;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_shift;

      if (i == 0) begin : g_head
         assign left_entry = '{valid: 1'b1, task_id: 8'd0, prio: 16'd0};
         assign left_shift = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_shift = cell_shift[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = '{valid: 1'b0, task_id: 8'd0, prio: 16'd0};
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      prq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .bcast       (bcast),
         .left_entry  (left_entry),
         .left_shift  (left_shift),
         .right_entry (right_entry),
         .hit_in      (hit_chain[i]),
         .entry       (cell_entry[i]),
         .shift_out   (cell_shift[i]),
         .hit_out     (hit_chain[i+1])
      );
   end

   always_comb begin
      rsp_in.out_task_id  = req_payload.task_id;
      rsp_in.out_priority = 16'd0;
      rsp_in.status       = ST_OK;
      rsp_in.preempt      = 1'b0;
      unique case (req_payload.cmd)
         CMD_ENQUEUE: begin
            if (is_full) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.preempt = 1'b1;
            end
         end
         CMD_DEQUEUE: begin
            if (is_empty) begin
               rsp_in.out_task_id = 8'd0;
               rsp_in.status      = ST_EMPTY;
            end else begin
               rsp_in.out_task_id  = cell_entry[0].task_id;
               rsp_in.out_priority = cell_entry[0].prio;
            end
         end
         CMD_REMOVE: begin
            if (!found) begin
               rsp_in.status = ST_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Occupied slots always form a run starting at the head.
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      cell_entry[CAPACITY-1].valid |-> cell_entry[0].valid)
      else $error("tail slot valid while head slot empty");

   a_preempt_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.preempt) |-> (rsp_payload.status == ST_OK))
      else $error("preempt raised on a refused item");

   a_enqueue_fills: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.cmd == CMD_ENQUEUE && !is_full) |=> cell_entry[0].valid)
      else $error("queue empty after an accepted enqueue");

   a_empty_stays: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.cmd != CMD_ENQUEUE && is_empty) |=> !cell_entry[0].valid)
      else $error("empty queue gained an entry without enqueue");

endmodule
`default_nettype wire

@@ rtl/prq_cell.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// prq_cell
// One slot of the sorted queue: holds an entry and moves it to or from its
// neighbors on enqueue, dequeue and remove.
// -----------------------------------------------------------------------------
module prq_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  prq_pkg::bcast_type   bcast,
   input  prq_pkg::entry_type   left_entry,
   input  wire                  left_shift,
   input  prq_pkg::entry_type   right_entry,
   input  wire                  hit_in,
   output prq_pkg::entry_type   entry,
   output logic                 shift_out,
   output logic                 hit_out
);
   import prq_pkg::*;

   logic        valid_ff, valid_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] prio_ff, prio_in;
   logic        match;
   logic        insert_here;

   // Entries with a worse priority move one slot toward the tail on enqueue.
   assign shift_out = valid_ff && (prio_ff > bcast.prio);
   assign match     = valid_ff && (id_ff == bcast.task_id);
   // First matching slot and everything behind it close the gap on remove.
   assign hit_out   = hit_in | match;
   assign insert_here = !left_shift && (shift_out || (!valid_ff && left_entry.valid));

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      prio_in  = prio_ff;
      if (bcast.fire) begin
         case (bcast.cmd)
            CMD_ENQUEUE: begin
               if (!bcast.full) begin
                  if (left_shift) begin
                     valid_in = left_entry.valid;
                     id_in    = left_entry.task_id;
                     prio_in  = left_entry.prio;
                  end else if (insert_here) begin
                     valid_in = 1'b1;
                     id_in    = bcast.task_id;
                     prio_in  = bcast.prio;
                  end
               end
            end
            CMD_DEQUEUE: begin
               valid_in = right_entry.valid;
               id_in    = right_entry.task_id;
               prio_in  = right_entry.prio;
            end
            CMD_REMOVE: begin
               if (hit_out) begin
                  valid_in = right_entry.valid;
                  id_in    = right_entry.task_id;
                  prio_in  = right_entry.prio;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

   assign entry.valid   = valid_ff;
   assign entry.task_id = id_ff;
   assign entry.prio    = prio_ff;

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the priority run queue. A short table of commands
// covers empty, full, not found, duplicate ids, stable ties and the unused
// command code. A long random run follows that fills and drains the queue
// under four phases of sender idling and receiver stalls. Every response is
// checked field by field against its table row or a sorted-array bench model.
// -----------------------------------------------------------------------------
module tb;
   import prq_pkg::*;

   localparam int CAPACITY       = 16;
   localparam int RAND_ITEMS     = 1700;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int NUM_DIR_ROWS   = 13;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int IDLE_PCT [4]  = '{0, 70, 0, 38};
   localparam int STALL_PCT [4] = '{0, 0, 70, 38};

   typedef struct packed {
      req_type    item;
      logic [7:0] reps;     // repeat count, task_id bumped on each repeat
      logic       hand;     // want is typed in, else the model decides
      rsp_type    want;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [NUM_DIR_ROWS] = '{
      '{'{CMD_DEQUEUE, 8'h00, 16'h0000}, 8'd1,  1'b1, '{8'h00, 16'h0000, ST_EMPTY, 1'b0}},
      '{'{CMD_REMOVE,  8'hFF, 16'h0000}, 8'd1,  1'b1, '{8'hFF, 16'h0000, ST_NOT_FOUND, 1'b0}},
      '{'{CMD_UNUSED,  8'hA5, 16'hFFFF}, 8'd1,  1'b1, '{8'hA5, 16'h0000, ST_OK, 1'b0}},
      '{'{CMD_ENQUEUE, 8'h00, 16'hFFFF}, 8'd1,  1'b1, '{8'h00, 16'h0000, ST_OK, 1'b1}},
      '{'{CMD_ENQUEUE, 8'hFF, 16'h0000}, 8'd1,  1'b1, '{8'hFF, 16'h0000, ST_OK, 1'b1}},
      '{'{CMD_ENQUEUE, 8'h07, 16'h0000}, 8'd1,  1'b0, '0},
      '{'{CMD_ENQUEUE, 8'h07, 16'hFFFF}, 8'd1,  1'b0, '0},
      '{'{CMD_REMOVE,  8'h07, 16'h0000}, 8'd1,  1'b1, '{8'h07, 16'h0000, ST_OK, 1'b0}},
      '{'{CMD_DEQUEUE, 8'h00, 16'h0000}, 8'd1,  1'b1, '{8'hFF, 16'h0000, ST_OK, 1'b0}},
      '{'{CMD_ENQUEUE, 8'h10, 16'h8000}, 8'd14, 1'b0, '0},
      '{'{CMD_ENQUEUE, 8'h5A, 16'h1234}, 8'd1,  1'b1, '{8'h5A, 16'h0000, ST_FULL, 1'b0}},
      '{'{CMD_REMOVE,  8'hEE, 16'h0000}, 8'd1,  1'b1, '{8'hEE, 16'h0000, ST_NOT_FOUND, 1'b0}},
      '{'{CMD_DEQUEUE, 8'h3C, 16'h4321}, 8'd1,  1'b0, '0}
   };

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // model of the queue contents, head at index 0
   logic [7:0]  model_ids [CAPACITY];
   logic [15:0] model_prios [CAPACITY];
   int          model_count = 0;

   rsp_type expected_rsp_q [$];
   logic    hand_flag_q [$];
   rsp_type hand_rsp_q [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;
   int fail_count     = 0;

   priority_run_queue #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_type run_queue_step(req_type r);
      rsp_type res;
      int      pos;
      int      k;
      bit      found;
      res = '{r.task_id, 16'h0000, ST_OK, 1'b0};
      pos = 0;
      found = 1'b0;
      case (r.cmd)
         CMD_ENQUEUE: begin
            if (model_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               // stable insert: behind every entry with equal or better priority
               while (pos < model_count && model_prios[pos] <= r.priority_req) pos++;
               for (k = model_count; k > pos; k--) begin
                  model_ids[k]   = model_ids[k - 1];
                  model_prios[k] = model_prios[k - 1];
               end
               model_ids[pos]   = r.task_id;
               model_prios[pos] = r.priority_req;
               model_count++;
               res.preempt = 1'b1;
            end
         end
         CMD_DEQUEUE: begin
            if (model_count == 0) begin
               res.out_task_id = 8'h00;
               res.status      = ST_EMPTY;
            end else begin
               res.out_task_id  = model_ids[0];
               res.out_priority = model_prios[0];
               found = 1'b1;
            end
         end
         CMD_REMOVE: begin
            while (pos < model_count && !found) begin
               if (model_ids[pos] == r.task_id) found = 1'b1;
               else pos++;
            end
            if (!found) res.status = ST_NOT_FOUND;
         end
         default: ;
      endcase
      if (found) begin
         for (k = pos; k + 1 < model_count; k++) begin
            model_ids[k]   = model_ids[k + 1];
            model_prios[k] = model_prios[k + 1];
         end
         model_count--;
      end
      return res;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic drive_item(req_type item, logic hand, rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      hand_flag_q.push_back(hand);
      hand_rsp_q.push_back(want);
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // accept, predict and check on the rising edge
   rsp_type predicted;
   rsp_type want_rsp;
   logic    use_hand;
   logic    moved;

   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && req_ready) begin
            moved     = 1'b1;
            predicted = run_queue_step(req_payload);
            use_hand  = hand_flag_q.pop_front();
            want_rsp  = hand_rsp_q.pop_front();
            expected_rsp_q.push_back(use_hand ? want_rsp : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (expected_rsp_q.size() == 0) begin
               $error("response item with no expectation: %h", rsp_payload);
               fail_count++;
            end else begin
               want_rsp = expected_rsp_q.pop_front();
               if (rsp_payload.out_task_id !== want_rsp.out_task_id) begin
                  $error("out_task_id: expected %0h, got %0h",
                         want_rsp.out_task_id, rsp_payload.out_task_id);
                  fail_count++;
               end
               if (rsp_payload.out_priority !== want_rsp.out_priority) begin
                  $error("out_priority: expected %0h, got %0h",
                         want_rsp.out_priority, rsp_payload.out_priority);
                  fail_count++;
               end
               if (rsp_payload.status !== want_rsp.status) begin
                  $error("status: expected %0d, got %0d",
                         want_rsp.status, rsp_payload.status);
                  fail_count++;
               end
               if (rsp_payload.preempt !== want_rsp.preempt) begin
                  $error("preempt: expected %0b, got %0b",
                         want_rsp.preempt, rsp_payload.preempt);
                  fail_count++;
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      req_type item;
      int      i;
      int      k;
      int      ph;
      int      n;
      int      p;
      bit      filling;
      filling = 1'b1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIR_ROWS; i++) begin
         for (k = 0; k < DIR_ROWS[i].reps; k++) begin
            item = DIR_ROWS[i].item;
            item.task_id = item.task_id + 8'(k);
            drive_item(item, DIR_ROWS[i].hand, DIR_ROWS[i].want);
         end
      end

      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct  = IDLE_PCT[ph];
         recv_stall_pct = STALL_PCT[ph];
         for (n = 0; n < RAND_ITEMS / 4; n++) begin
            // swing between filling and draining, lingering at full and empty
            if (filling && model_count == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
            if (!filling && model_count == 0 && $urandom_range(3) == 0) filling = 1'b1;
            if ($urandom_range(199) == 0) filling = !filling;

            p = $urandom_range(99);
            if (filling) begin
               item.cmd = (p < 75) ? CMD_ENQUEUE : (p < 88) ? CMD_DEQUEUE :
                          (p < 97) ? CMD_REMOVE : CMD_UNUSED;
            end else begin
               item.cmd = (p < 15) ? CMD_ENQUEUE : (p < 60) ? CMD_DEQUEUE :
                          (p < 95) ? CMD_REMOVE : CMD_UNUSED;
            end

            // small id pool gives duplicates
            item.task_id = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
            if (item.cmd == CMD_REMOVE && model_count > 0 && $urandom_range(99) < 70)
               item.task_id = model_ids[$urandom_range(model_count - 1)];

            case ($urandom_range(3))
               0: item.priority_req = 16'($urandom_range(3));
               1: item.priority_req = $urandom_range(1) ? 16'hFFFF : 16'h0000;
               default: item.priority_req = 16'($urandom_range(65535));
            endcase

            drive_item(item, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
